// ===== src/r2fft_pkg.sv =====
// Shared constants, types and table functions of the radix-2 FFT block.
`timescale 1ns / 1ps
`default_nettype none

package r2fft_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int TW_BITS     = 16;
    localparam int TW_FRAC     = TW_BITS - 1;
    localparam int LOG_MAX     = $clog2(MAX_POINTS);
    localparam int ADDR_W      = LOG_MAX;
    localparam int CNT_W       = LOG_MAX + 1;
    localparam int DATA_W      = 32;
    localparam int WORD_W      = 2 * DATA_W;
    localparam int QUARTER     = MAX_POINTS / 4;
    localparam int QUARTER_HALF = QUARTER / 2;
    localparam int Q_W         = LOG_MAX - 2;
    localparam int LOG_W       = 4;
    localparam int MODE_W      = 2;
    localparam int BIN_W       = 10;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int PROD_W      = DATA_W + 1 + TW_BITS;
    localparam int QDEPTH      = 2;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint S32_MAX     = 64'sd2147483647;
    localparam longint S32_MIN     = -64'sd2147483648;

    // Rounded-up reciprocals in Q64 of the Taylor step divisors (2k)(2k+1).
    localparam logic [63:0] TAYLOR_RECIP [8] = '{
        64'(((65'd1 << 64) / 65'd6) + 65'd1),
        64'(((65'd1 << 64) / 65'd20) + 65'd1),
        64'(((65'd1 << 64) / 65'd42) + 65'd1),
        64'(((65'd1 << 64) / 65'd72) + 65'd1),
        64'(((65'd1 << 64) / 65'd110) + 65'd1),
        64'(((65'd1 << 64) / 65'd156) + 65'd1),
        64'(((65'd1 << 64) / 65'd210) + 65'd1),
        64'(((65'd1 << 64) / 65'd272) + 65'd1)
    };

    localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INV  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REAL = 2'd2;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_LOG  = 1'b1;

    typedef enum logic {
        OP_LOAD,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [DATA_W-1:0]  re;
        logic [DATA_W-1:0]  im;
    } cmd_t;

    typedef struct packed {
        logic              inverse;
        logic              real_mode;
        logic [LOG_W-1:0]  l;
        logic [LOG_W-1:0]  lg;
        logic [CNT_W-1:0]  items;
    } cfg_t;

    typedef struct packed {
        logic [TW_BITS-1:0] c;
        logic [TW_BITS-1:0] s;
    } tw_t;

    typedef logic [TW_FRAC-1:0] qsin_arr_t [QUARTER+1];

    // Quarter-wave sine in unsigned Q0.15, from a Q30 Taylor series through x^17.
    // The terms stay non-negative, so each step divides exactly through its reciprocal.
    function automatic qsin_arr_t build_qsin();
        qsin_arr_t t;
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint v;
        logic [63:0]  n;
        logic [127:0] prod;
        for (int p = 0; p <= QUARTER; p++)
        begin
            x = (longint'(p) * HALF_PI_Q30 + QUARTER_HALF) >>> Q_W;
            x2 = (x * x) >>> 30;
            term = x;
            sum = x;
            for (int k = 1; k <= 8; k++)
            begin
                n = 64'((term * x2) >>> 30);
                prod = {64'd0, n} * {64'd0, TAYLOR_RECIP[k-1]};
                term = longint'(prod[127:64]);
                if ((k & 1) == 1)
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            v = (sum + (longint'(1) <<< (29 - TW_FRAC))) >>> (30 - TW_FRAC);
            if (v > (longint'(1) <<< TW_FRAC) - 1)
            begin
                v = (longint'(1) <<< TW_FRAC) - 1;
            end
            if (v < 0)
            begin
                v = 0;
            end
            t[p] = TW_FRAC'(v);
        end
        return t;
    endfunction

    localparam qsin_arr_t QSIN = build_qsin();

    function automatic logic [TW_BITS-1:0] wave(input logic [ADDR_W-1:0] p);
        logic [1:0]     q;
        logic [Q_W:0]   r;
        logic [Q_W:0]   idx;
        logic [TW_BITS-1:0] mag;
        q = p[ADDR_W-1 -: 2];
        r = {1'b0, p[Q_W-1:0]};
        idx = q[0] ? ((Q_W + 1)'(QUARTER) - r) : r;
        mag = {1'b0, QSIN[idx]};
        return q[1] ? (TW_BITS'(0) - mag) : mag;
    endfunction

    function automatic tw_t twiddle(input logic [ADDR_W-1:0] t);
        tw_t w;
        w.c = wave(t + ADDR_W'(QUARTER));
        w.s = wave(t);
        return w;
    endfunction

    function automatic logic [ADDR_W-1:0] bitrev(input logic [ADDR_W-1:0] v,
                                                 input logic [LOG_W-1:0] lg);
        logic [ADDR_W-1:0] r;
        for (int b = 0; b < ADDR_W; b++)
        begin
            r[ADDR_W-1-b] = v[b];
        end
        return r >> (LOG_W'(ADDR_W) - lg);
    endfunction

    function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX)
        begin
            return DATA_W'(S32_MAX);
        end
        if (v < S32_MIN)
        begin
            return DATA_W'(S32_MIN);
        end
        return DATA_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== src/r2fft_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module r2fft_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     rea,
    input  wire logic [$clog2(DEPTH)-1:0] raddra,
    output logic      [WIDTH-1:0]         rdataa,
    input  wire logic                     reb,
    input  wire logic [$clog2(DEPTH)-1:0] raddrb,
    output logic      [WIDTH-1:0]         rdatab
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rea)
        begin
            rdataa <= mem[raddra];
        end
        if (reb)
        begin
            rdatab <= mem[raddrb];
        end
    end

endmodule

`default_nettype wire

// ===== src/r2fft_front.sv =====
// Front end: configuration registers, mode decoding and input word classification.
`timescale 1ns / 1ps
`default_nettype none

module r2fft_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [r2fft_pkg::APB_AW-1:0]        paddr,
    input  wire logic [r2fft_pkg::APB_DW-1:0]        pwdata,
    output logic      [r2fft_pkg::APB_DW-1:0]        prdata,
    output logic                                     pready,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                action,
    input  wire logic signed [r2fft_pkg::SAMPLE_BITS-1:0] in_re,
    input  wire logic signed [r2fft_pkg::SAMPLE_BITS-1:0] in_im,
    input  wire logic                                q_full,
    output logic                                     q_push,
    output r2fft_pkg::cmd_t                          q_data,
    output r2fft_pkg::cfg_t                          cfg,
    output logic                                     cfg_wr
);

    logic [r2fft_pkg::MODE_W-1:0] mode_reg;
    logic [r2fft_pkg::LOG_W-1:0]  log2_len_reg;
    logic [r2fft_pkg::LOG_W-1:0]  l_eff;
    logic [r2fft_pkg::MODE_W-1:0] md;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= r2fft_pkg::MODE_FWD;
            log2_len_reg <= r2fft_pkg::LOG_W'(r2fft_pkg::LOG_MAX);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                r2fft_pkg::REG_MODE: mode_reg     <= pwdata[r2fft_pkg::MODE_W-1:0];
                r2fft_pkg::REG_LOG:  log2_len_reg <= pwdata[r2fft_pkg::LOG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            r2fft_pkg::REG_MODE: prdata = r2fft_pkg::APB_DW'(mode_reg);
            r2fft_pkg::REG_LOG:  prdata = r2fft_pkg::APB_DW'(log2_len_reg);
            default:             prdata = '0;
        endcase
    end

    // Clamp the length and fold the unused mode code onto forward.
    always_comb
    begin
        if (log2_len_reg < r2fft_pkg::LOG_W'(2))
        begin
            l_eff = r2fft_pkg::LOG_W'(2);
        end
        else if (log2_len_reg > r2fft_pkg::LOG_W'(r2fft_pkg::LOG_MAX))
        begin
            l_eff = r2fft_pkg::LOG_W'(r2fft_pkg::LOG_MAX);
        end
        else
        begin
            l_eff = log2_len_reg;
        end
        unique case (mode_reg)
            r2fft_pkg::MODE_INV:  md = r2fft_pkg::MODE_INV;
            r2fft_pkg::MODE_REAL: md = r2fft_pkg::MODE_REAL;
            default:              md = r2fft_pkg::MODE_FWD;
        endcase
        cfg.inverse   = (md == r2fft_pkg::MODE_INV);
        cfg.real_mode = (md == r2fft_pkg::MODE_REAL);
        cfg.l         = l_eff;
        cfg.lg        = cfg.real_mode ? (l_eff - r2fft_pkg::LOG_W'(1)) : l_eff;
        cfg.items     = r2fft_pkg::CNT_W'(1) << cfg.lg;
    end

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        q_data.op = action ? r2fft_pkg::OP_READ : r2fft_pkg::OP_LOAD;
        q_data.re = r2fft_pkg::DATA_W'(in_re);
        q_data.im = r2fft_pkg::DATA_W'(in_im);
    end

endmodule

`default_nettype wire

// ===== src/r2fft_queue.sv =====
// Two-entry command queue between the front end and the transform engine.
`timescale 1ns / 1ps
`default_nettype none

module r2fft_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  r2fft_pkg::cmd_t      din,
    output logic                 full,
    input  wire logic            pop,
    output r2fft_pkg::cmd_t      dout,
    output logic                 empty
);

    localparam int PTR_W = $clog2(r2fft_pkg::QDEPTH);

    r2fft_pkg::cmd_t        mem [r2fft_pkg::QDEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W:0]         count_reg;

    assign full  = (count_reg == (PTR_W + 1)'(r2fft_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (PTR_W + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/r2fft_back.sv =====
// Transform engine: sample store, butterfly sequencer, real split and result register.
`timescale 1ns / 1ps
`default_nettype none

module r2fft_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  r2fft_pkg::cfg_t                       cfg,
    input  wire logic                             cfg_wr,
    input  wire logic                             q_empty,
    input  r2fft_pkg::cmd_t                       q_data,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  wire logic                             pop,
    output logic [r2fft_pkg::BIN_W-1:0]           bin_index,
    output logic signed [r2fft_pkg::DATA_W-1:0]   out_re,
    output logic signed [r2fft_pkg::DATA_W-1:0]   out_im,
    output logic                                  last_bin
);

    localparam int AW = r2fft_pkg::ADDR_W;
    localparam int DW = r2fft_pkg::DATA_W;
    localparam int WW = r2fft_pkg::WORD_W;
    localparam int CW = r2fft_pkg::CNT_W;
    localparam int LW = r2fft_pkg::LOG_W;
    localparam int PW = r2fft_pkg::PROD_W;
    localparam int TB = r2fft_pkg::TW_BITS;
    localparam int TF = r2fft_pkg::TW_FRAC;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OUT,
        F_RD,
        F_PRE,
        F_MUL,
        F_SUM,
        F_BF,
        F_WR,
        X0_RD,
        X0_WR,
        XM_WR
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          lc_reg;
    logic [CW-1:0]          rc_reg;
    logic                   ready_reg;
    logic [LW-1:0]          stage_reg;
    logic [AW-2:0]          cnt_reg;
    logic                   split_reg;
    logic [AW-1:0]          ia_reg;
    logic [AW-1:0]          ja_reg;
    logic signed [TB-1:0]   tw_c_reg;
    logic signed [TB-1:0]   tw_s_reg;
    logic                   k0_reg;
    logic signed [DW:0]     ar_reg;
    logic signed [DW:0]     ai_reg;
    logic signed [DW:0]     u_reg;
    logic signed [DW:0]     v_reg;
    logic signed [PW-1:0]   m0_reg;
    logic signed [PW-1:0]   m1_reg;
    logic signed [PW-1:0]   m2_reg;
    logic signed [PW-1:0]   m3_reg;
    logic signed [PW:0]     p_reg;
    logic signed [PW:0]     q_reg;
    logic [WW-1:0]          second_reg;
    logic                   out_valid_reg;
    logic [r2fft_pkg::BIN_W-1:0] bin_reg;
    logic [DW-1:0]          out_re_reg;
    logic [DW-1:0]          out_im_reg;
    logic                   last_reg;

    logic                   we;
    logic [AW-1:0]          waddr;
    logic [WW-1:0]          wdata;
    logic                   rea;
    logic [AW-1:0]          raddra;
    logic [WW-1:0]          rdataa;
    logic                   reb;
    logic [AW-1:0]          raddrb;
    logic [WW-1:0]          rdatab;

    logic                   is_load;
    logic [CW-1:0]          lc_base;
    logic [CW-1:0]          lc_inc;
    logic [AW-1:0]          load_addr;
    logic                   slot_free;

    logic [AW-1:0]          half;
    logic [AW-1:0]          bfx;
    logic [AW-1:0]          k_idx;
    logic [AW-1:0]          bi;
    logic [AW-1:0]          bj;
    logic [AW-1:0]          btw;
    logic [AW-1:0]          m_pts;
    logic [AW-1:0]          mid;
    logic [AW-1:0]          sj;
    logic [AW-1:0]          stw;
    logic [AW-1:0]          rd_i;
    logic [AW-1:0]          rd_j;
    logic [AW-2:0]          bf_last;
    logic [AW-2:0]          sp_last;
    r2fft_pkg::tw_t         tw_look;

    logic signed [63:0]     ire;
    logic signed [63:0]     iim;
    logic signed [63:0]     jre;
    logic signed [63:0]     jim;
    logic signed [63:0]     sr;
    logic signed [63:0]     si;
    logic signed [63:0]     ar64;
    logic signed [63:0]     ai64;
    logic signed [63:0]     p64;
    logic signed [63:0]     q64;
    logic signed [63:0]     sa;
    logic signed [63:0]     sb;
    logic signed [63:0]     rnd;
    logic [WW-1:0]          first_word;
    logic [WW-1:0]          second_word;
    logic signed [63:0]     scaled_re;
    logic signed [63:0]     scaled_im;
    logic signed [63:0]     half_lsb;

    r2fft_ram #(
        .WIDTH (WW),
        .DEPTH (r2fft_pkg::MAX_POINTS)
    ) u_store (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .rea    (rea),
        .raddra (raddra),
        .rdataa (rdataa),
        .reb    (reb),
        .raddrb (raddrb),
        .rdatab (rdatab)
    );

    assign out_valid = out_valid_reg;
    assign bin_index = bin_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign last_bin  = last_reg;

    // Samples go straight to their bit-reversed slot, so no reorder pass is needed.
    assign is_load   = (q_data.op == r2fft_pkg::OP_LOAD);
    assign lc_base   = (ready_reg || lc_reg >= cfg.items) ? '0 : lc_reg;
    assign lc_inc    = lc_base + CW'(1);
    assign load_addr = r2fft_pkg::bitrev(lc_base[AW-1:0], cfg.lg);
    assign slot_free = !out_valid_reg || pop;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty
                       && (is_load || !ready_reg || slot_free);

    always_comb
    begin
        half    = AW'(1) << (stage_reg - LW'(1));
        bfx     = {1'b0, cnt_reg};
        k_idx   = bfx & (half - AW'(1));
        bi      = ((bfx >> (stage_reg - LW'(1))) << stage_reg) | k_idx;
        bj      = bi | half;
        btw     = k_idx << (LW'(r2fft_pkg::LOG_MAX) - stage_reg);
        m_pts   = cfg.items[AW-1:0];
        mid     = m_pts >> 1;
        sj      = m_pts - bfx;
        stw     = bfx << (LW'(r2fft_pkg::LOG_MAX) - cfg.l);
        rd_i    = split_reg ? bfx : bi;
        rd_j    = split_reg ? sj : bj;
        bf_last = (AW - 1)'((AW'(1) << (cfg.lg - LW'(1))) - AW'(1));
        sp_last = (AW - 1)'(mid - AW'(1));
        tw_look = r2fft_pkg::twiddle(split_reg ? stw : btw);
    end

    always_comb
    begin
        ire = 64'($signed(rdataa[WW-1:DW]));
        iim = 64'($signed(rdataa[DW-1:0]));
        jre = 64'($signed(rdatab[WW-1:DW]));
        jim = 64'($signed(rdatab[DW-1:0]));
        if (cfg.inverse && !split_reg)
        begin
            sr = 64'(m0_reg) - 64'(m1_reg);
            si = 64'(m2_reg) + 64'(m3_reg);
        end
        else
        begin
            sr = 64'(m0_reg) + 64'(m1_reg);
            si = 64'(m2_reg) - 64'(m3_reg);
        end
        ar64 = 64'(ar_reg);
        ai64 = 64'(ai_reg);
        p64  = 64'(p_reg);
        q64  = 64'(q_reg);
        sa   = ar64 <<< TF;
        sb   = ai64 <<< TF;
        rnd  = 64'sd1 <<< TF;
        if (split_reg)
        begin
            first_word  = {r2fft_pkg::sat32((sa + p64 + rnd) >>> (TF + 1)),
                           r2fft_pkg::sat32((sb + q64 + rnd) >>> (TF + 1))};
            second_word = {r2fft_pkg::sat32((sa - p64 + rnd) >>> (TF + 1)),
                           r2fft_pkg::sat32((q64 - sb + rnd) >>> (TF + 1))};
        end
        else
        begin
            first_word  = {r2fft_pkg::sat32(ar64 - p64), r2fft_pkg::sat32(ai64 - q64)};
            second_word = {r2fft_pkg::sat32(ar64 + p64), r2fft_pkg::sat32(ai64 + q64)};
        end
        // The inverse transform divides by the length on the way out.
        half_lsb  = 64'sd1 <<< (cfg.l - LW'(1));
        scaled_re = cfg.inverse ? ((ire + half_lsb) >>> cfg.l) : ire;
        scaled_im = cfg.inverse ? ((iim + half_lsb) >>> cfg.l) : iim;
    end

    always_comb
    begin
        we     = 1'b0;
        waddr  = '0;
        wdata  = '0;
        rea    = 1'b0;
        raddra = '0;
        reb    = 1'b0;
        raddrb = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop && is_load)
                begin
                    we    = 1'b1;
                    waddr = load_addr;
                    wdata = {q_data.re, q_data.im};
                end
                if (q_pop && !is_load && ready_reg)
                begin
                    rea    = 1'b1;
                    raddra = rc_reg[AW-1:0];
                end
            end
            F_RD:
            begin
                rea    = 1'b1;
                raddra = rd_i;
                reb    = 1'b1;
                raddrb = rd_j;
            end
            F_BF:
            begin
                we    = 1'b1;
                waddr = split_reg ? ia_reg : ja_reg;
                wdata = first_word;
            end
            F_WR:
            begin
                we    = 1'b1;
                waddr = split_reg ? ja_reg : ia_reg;
                wdata = second_reg;
            end
            X0_RD:
            begin
                rea    = 1'b1;
                raddra = '0;
                reb    = 1'b1;
                raddrb = mid;
            end
            X0_WR:
            begin
                we    = 1'b1;
                waddr = '0;
                wdata = {r2fft_pkg::sat32(ire + iim), DW'(0)};
            end
            XM_WR:
            begin
                we    = 1'b1;
                waddr = mid;
                wdata = {rdatab[WW-1:DW], r2fft_pkg::sat32(-jim)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lc_reg        <= '0;
            rc_reg        <= '0;
            ready_reg     <= 1'b0;
            stage_reg     <= '0;
            cnt_reg       <= '0;
            split_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && is_load)
                    begin
                        if (ready_reg)
                        begin
                            ready_reg <= 1'b0;
                            rc_reg    <= '0;
                        end
                        lc_reg <= lc_inc;
                        if (lc_inc == cfg.items)
                        begin
                            state_reg <= F_RD;
                            stage_reg <= LW'(1);
                            cnt_reg   <= '0;
                            split_reg <= 1'b0;
                        end
                    end
                    else if (q_pop && ready_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    bin_reg       <= r2fft_pkg::BIN_W'(rc_reg);
                    out_re_reg    <= DW'(scaled_re);
                    out_im_reg    <= DW'(scaled_im);
                    last_reg      <= (rc_reg + CW'(1) >= cfg.items);
                    if (rc_reg + CW'(1) >= cfg.items)
                    begin
                        ready_reg <= 1'b0;
                        rc_reg    <= '0;
                        lc_reg    <= '0;
                    end
                    else
                    begin
                        rc_reg <= rc_reg + CW'(1);
                    end
                    state_reg <= S_IDLE;
                end
                F_RD:
                begin
                    ia_reg    <= rd_i;
                    ja_reg    <= rd_j;
                    tw_c_reg  <= tw_look.c;
                    tw_s_reg  <= tw_look.s;
                    k0_reg    <= (k_idx == '0);
                    state_reg <= F_PRE;
                end
                F_PRE:
                begin
                    if (split_reg)
                    begin
                        ar_reg <= (DW + 1)'(ire + jre);
                        ai_reg <= (DW + 1)'(iim - jim);
                        u_reg  <= (DW + 1)'(iim + jim);
                        v_reg  <= (DW + 1)'(jre - ire);
                    end
                    else
                    begin
                        ar_reg <= (DW + 1)'(ire);
                        ai_reg <= (DW + 1)'(iim);
                        u_reg  <= (DW + 1)'(jre);
                        v_reg  <= (DW + 1)'(jim);
                    end
                    state_reg <= F_MUL;
                end
                F_MUL:
                begin
                    m0_reg    <= u_reg * tw_c_reg;
                    m1_reg    <= v_reg * tw_s_reg;
                    m2_reg    <= v_reg * tw_c_reg;
                    m3_reg    <= u_reg * tw_s_reg;
                    state_reg <= F_SUM;
                end
                F_SUM:
                begin
                    if (split_reg)
                    begin
                        p_reg <= (PW + 1)'(sr);
                        q_reg <= (PW + 1)'(si);
                    end
                    else if (k0_reg)
                    begin
                        p_reg <= (PW + 1)'(u_reg);
                        q_reg <= (PW + 1)'(v_reg);
                    end
                    else
                    begin
                        p_reg <= (PW + 1)'($signed(r2fft_pkg::sat32(
                                     (sr + (64'sd1 <<< (TF - 1))) >>> TF)));
                        q_reg <= (PW + 1)'($signed(r2fft_pkg::sat32(
                                     (si + (64'sd1 <<< (TF - 1))) >>> TF)));
                    end
                    state_reg <= F_BF;
                end
                F_BF:
                begin
                    second_reg <= second_word;
                    state_reg  <= F_WR;
                end
                F_WR:
                begin
                    if (split_reg)
                    begin
                        if (cnt_reg == sp_last)
                        begin
                            state_reg <= S_IDLE;
                            ready_reg <= 1'b1;
                            lc_reg    <= '0;
                            rc_reg    <= '0;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + (AW - 1)'(1);
                            state_reg <= F_RD;
                        end
                    end
                    else if (cnt_reg == bf_last)
                    begin
                        if (stage_reg == cfg.lg)
                        begin
                            if (cfg.real_mode)
                            begin
                                state_reg <= X0_RD;
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                                ready_reg <= 1'b1;
                                lc_reg    <= '0;
                                rc_reg    <= '0;
                            end
                        end
                        else
                        begin
                            stage_reg <= stage_reg + LW'(1);
                            cnt_reg   <= '0;
                            state_reg <= F_RD;
                        end
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + (AW - 1)'(1);
                        state_reg <= F_RD;
                    end
                end
                X0_RD:
                begin
                    state_reg <= X0_WR;
                end
                X0_WR:
                begin
                    state_reg <= XM_WR;
                end
                XM_WR:
                begin
                    // Bins zero and N/4 are done; the paired bins follow if any.
                    if (mid == AW'(1))
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                        lc_reg    <= '0;
                        rc_reg    <= '0;
                    end
                    else
                    begin
                        split_reg <= 1'b1;
                        cnt_reg   <= (AW - 1)'(1);
                        state_reg <= F_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_wr)
            begin
                lc_reg    <= '0;
                rc_reg    <= '0;
                ready_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/radix2_fft_complex_and_real_top.sv =====
// Top level of the fixed-point radix-2 FFT block.
// The input channel takes words with push/full: action 0 loads one sample
// (complex, or two consecutive real samples in real mode), action 1 asks for
// the next bin. Results leave through empty/pop with bin_index, out_re,
// out_im and last_bin; a read that finds no finished frame gives no word.
// Mode and log2_len are to be written over the APB port only while the block
// is idle; the block does not enforce this. Any such write drops the frame
// in progress. A load word is written to the sample memory as it is popped.
// The word that completes a frame starts the transform: lg stages of
// 2^(lg-1) butterflies each, every one through the states F_RD, F_PRE, F_MUL,
// F_SUM, F_BF and F_WR of the single butterfly unit and the two-read, one-write
// sample memory. Real mode adds X0_RD, X0_WR, XM_WR and one butterfly pass per
// bin pair for the split. A read word's result is registered out in S_OUT.
// A two-word command queue lets the input keep accepting while the engine
// works or while a result waits; if the receiver stalls, reads hold in the
// queue and full rises once it fills. Reset leaves forward mode at 1024
// points with no frame loaded; the sample memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module radix2_fft_complex_and_real_top (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic [r2fft_pkg::APB_AW-1:0]             paddr,
    input  wire logic [r2fft_pkg::APB_DW-1:0]             pwdata,
    output logic      [r2fft_pkg::APB_DW-1:0]             prdata,
    output logic                                          pready,
    input  wire logic                                     push,
    output logic                                          full,
    input  wire logic                                     action,
    input  wire logic signed [r2fft_pkg::SAMPLE_BITS-1:0] in_re,
    input  wire logic signed [r2fft_pkg::SAMPLE_BITS-1:0] in_im,
    output logic                                          empty,
    input  wire logic                                     pop,
    output logic      [r2fft_pkg::BIN_W-1:0]              bin_index,
    output logic signed [r2fft_pkg::DATA_W-1:0]           out_re,
    output logic signed [r2fft_pkg::DATA_W-1:0]           out_im,
    output logic                                          last_bin
);

    logic               q_full;
    logic               q_push;
    r2fft_pkg::cmd_t    q_din;
    r2fft_pkg::cmd_t    q_dout;
    logic               q_empty;
    logic               q_pop;
    r2fft_pkg::cfg_t    cfg;
    logic               cfg_wr;
    logic               out_valid;

    r2fft_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .action  (action),
        .in_re   (in_re),
        .in_im   (in_im),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_din),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    r2fft_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    r2fft_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_wr    (cfg_wr),
        .q_empty   (q_empty),
        .q_data    (q_dout),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .pop       (pop),
        .bin_index (bin_index),
        .out_re    (out_re),
        .out_im    (out_im),
        .last_bin  (last_bin)
    );

    assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== dv/radix2_fft_complex_and_real_top_tb.sv =====
// Self-checking testbench for the radix-2 FFT block: directed table, random frames, own predictor.
`timescale 1ns / 1ps

module radix2_fft_complex_and_real_top_tb;

    localparam logic [2:0] ADDR_MODE = 3'd0;
    localparam logic [2:0] ADDR_LOG  = 3'd4;
    localparam logic       ACT_LOAD  = 1'b0;
    localparam logic       ACT_READ  = 1'b1;
    localparam int         STALL_LIMIT = 200000;
    localparam int         ITEM_GOAL   = 1900;
    localparam int         CALM_AFTER  = 1650;

    typedef struct {
        bit [9:0]  bin;
        bit [31:0] re;
        bit [31:0] im;
        bit        last;
    } bin_result_t;

    typedef struct {
        bit        act;
        int        re;
        int        im;
        bit        typed;
        int        ebin;
        int        ere;
        int        eim;
        bit        elast;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [r2fft_pkg::APB_AW-1:0] paddr;
    logic [r2fft_pkg::APB_DW-1:0] pwdata;
    logic [r2fft_pkg::APB_DW-1:0] prdata;
    logic pready;
    logic push, full, action, empty, pop, last_bin;
    logic signed [r2fft_pkg::SAMPLE_BITS-1:0] in_re, in_im;
    logic [r2fft_pkg::BIN_W-1:0] bin_index;
    logic signed [r2fft_pkg::DATA_W-1:0] out_re, out_im;

    radix2_fft_complex_and_real_top dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .action(action), .in_re(in_re), .in_im(in_im),
        .empty(empty), .pop(pop), .bin_index(bin_index), .out_re(out_re),
        .out_im(out_im), .last_bin(last_bin)
    );

    // Predictor state.
    longint fr_re [1024];
    longint fr_im [1024];
    longint cos_t [1024];
    longint sin_t [1024];
    longint qsine [257];
    logic [1:0] cur_mode;
    logic [3:0] cur_log;
    int loaded, bins_read;
    bit have_frame;

    bin_result_t pending_bins [$];
    int errors;
    int items_sent;
    bit calm;
    bit last_was_load;
    int idle_cycles;
    int pop_hold;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Floor of (v + half) / 2^sh.
    function automatic longint round_shift(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint wave_at(input int p);
        int q;
        int r;
        q = (p / 256) & 3;
        r = p % 256;
        case (q)
            0: return qsine[r];
            1: return qsine[256 - r];
            2: return -qsine[r];
            default: return -qsine[256 - r];
        endcase
    endfunction

    task automatic build_twiddles();
        longint x, x2, term, total, v;
        for (int p = 0; p <= 256; p++)
        begin
            x = (longint'(p) * 64'sd1686629713 + 128) / 256;
            x2 = (x * x) >>> 30;
            term = x;
            total = x;
            for (int k = 1; k <= 8; k++)
            begin
                term = ((term * x2) >>> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                begin
                    total = total - term;
                end
                else
                begin
                    total = total + term;
                end
            end
            v = round_shift(total, 15);
            if (v > 32767)
            begin
                v = 32767;
            end
            if (v < 0)
            begin
                v = 0;
            end
            qsine[p] = v;
        end
        for (int p = 0; p < 1024; p++)
        begin
            cos_t[p] = wave_at((p + 256) % 1024);
            sin_t[p] = wave_at(p);
        end
    endtask

    function automatic int eff_log();
        if (cur_log < 2)
        begin
            return 2;
        end
        if (cur_log > 10)
        begin
            return 10;
        end
        return int'(cur_log);
    endfunction

    function automatic void transform(input int lg, input bit inv);
        int n, r, half, stp, j;
        longint t, c, s, xr, xi, pr, pim, ar, ai;
        n = 1 << lg;
        for (int i = 0; i < n; i++)
        begin
            r = 0;
            for (int b = 0; b < lg; b++)
            begin
                r = (r << 1) | ((i >> b) & 1);
            end
            if (i < r)
            begin
                t = fr_re[i]; fr_re[i] = fr_re[r]; fr_re[r] = t;
                t = fr_im[i]; fr_im[i] = fr_im[r]; fr_im[r] = t;
            end
        end
        for (int st = 1; st <= lg; st++)
        begin
            half = 1 << (st - 1);
            stp = 1024 >> st;
            for (int k = 0; k < half; k++)
            begin
                c = cos_t[k * stp];
                s = sin_t[k * stp];
                for (int i = k; i < n; i += 2 * half)
                begin
                    j = i + half;
                    xr = fr_re[j]; xi = fr_im[j];
                    ar = fr_re[i]; ai = fr_im[i];
                    if (k == 0)
                    begin
                        pr = xr; pim = xi;
                    end
                    else if (!inv)
                    begin
                        pr = clamp32(round_shift(xr * c + xi * s, 15));
                        pim = clamp32(round_shift(xi * c - xr * s, 15));
                    end
                    else
                    begin
                        pr = clamp32(round_shift(xr * c - xi * s, 15));
                        pim = clamp32(round_shift(xr * s + xi * c, 15));
                    end
                    fr_re[j] = clamp32(ar - pr);
                    fr_im[j] = clamp32(ai - pim);
                    fr_re[i] = clamp32(ar + pr);
                    fr_im[i] = clamp32(ai + pim);
                end
            end
        end
    endfunction

    // Even/odd split of the half-length transform into real-input bins.
    function automatic void split_real(input int l);
        int m, stride, j;
        longint a, b, cr, d, c, s, p, q;
        m = 1 << (l - 1);
        stride = 1024 >> l;
        fr_re[0] = clamp32(fr_re[0] + fr_im[0]);
        fr_im[0] = 0;
        for (int i = 1; i < m / 2; i++)
        begin
            j = m - i;
            a = fr_re[i] + fr_re[j];
            b = fr_im[i] - fr_im[j];
            cr = fr_im[i] + fr_im[j];
            d = fr_re[j] - fr_re[i];
            c = cos_t[i * stride];
            s = sin_t[i * stride];
            p = cr * c + d * s;
            q = d * c - cr * s;
            fr_re[i] = clamp32(round_shift(a * 32768 + p, 16));
            fr_im[i] = clamp32(round_shift(b * 32768 + q, 16));
            fr_re[j] = clamp32(round_shift(a * 32768 - p, 16));
            fr_im[j] = clamp32(round_shift(q - b * 32768, 16));
        end
        fr_im[m / 2] = clamp32(-fr_im[m / 2]);
    endfunction

    function automatic int frame_words();
        if (cur_mode == r2fft_pkg::MODE_REAL)
        begin
            return 1 << (eff_log() - 1);
        end
        return 1 << eff_log();
    endfunction

    function automatic bit predict_word(input logic act, input logic signed [15:0] a,
                                        input logic signed [15:0] b,
                                        output bin_result_t r);
        int l, n;
        bit real_in, inv;
        l = eff_log();
        real_in = (cur_mode == r2fft_pkg::MODE_REAL);
        inv = (cur_mode == r2fft_pkg::MODE_INV);
        n = frame_words();
        if (act == ACT_LOAD)
        begin
            if (have_frame)
            begin
                loaded = 0; bins_read = 0; have_frame = 0;
            end
            if (loaded >= n)
            begin
                loaded = 0;
            end
            fr_re[loaded] = longint'(a);
            fr_im[loaded] = longint'(b);
            loaded++;
            if (loaded >= n)
            begin
                transform(real_in ? l - 1 : l, inv);
                if (inv)
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        fr_re[i] = round_shift(fr_re[i], l);
                        fr_im[i] = round_shift(fr_im[i], l);
                    end
                end
                if (real_in)
                begin
                    split_real(l);
                end
                loaded = 0; bins_read = 0; have_frame = 1;
            end
            return 0;
        end
        if (!have_frame || bins_read >= n)
        begin
            return 0;
        end
        r.bin = bins_read[9:0];
        r.re = fr_re[bins_read][31:0];
        r.im = fr_im[bins_read][31:0];
        bins_read++;
        r.last = (bins_read >= n);
        if (r.last)
        begin
            loaded = 0; bins_read = 0; have_frame = 0;
        end
        return 1;
    endfunction

    // Called right after a rising edge; returns after the edge that takes the word.
    task automatic send_word(input logic act, input logic signed [15:0] a,
                             input logic signed [15:0] b, input bit typed,
                             input bin_result_t tv);
        bin_result_t r;
        push <= 1'b1;
        action <= act;
        in_re <= a;
        in_im <= b;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        if (predict_word(act, a, b, r))
        begin
            pending_bins.push_back(typed ? tv : r);
        end
        last_was_load = (act == ACT_LOAD);
        items_sent++;
        if (items_sent >= CALM_AFTER)
        begin
            calm = 1;
        end
    endtask

    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 19);
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        int n, lg, wait_cycles;
        push <= 1'b0;
        @(posedge clk);
        while (pending_bins.size() != 0)
        begin
            @(posedge clk);
        end
        wait_cycles = 30;
        if (last_was_load)
        begin
            lg = (cur_mode == r2fft_pkg::MODE_REAL) ? eff_log() - 1 : eff_log();
            n = 1 << lg;
            wait_cycles = 6 * (n / 2) * lg + 12 * n + 200;
        end
        repeat (wait_cycles) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_MODE)
        begin
            cur_mode = val[1:0];
        end
        else
        begin
            cur_log = val[3:0];
        end
        loaded = 0; bins_read = 0; have_frame = 0;
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2, 3: return 16'($signed($urandom_range(0, 255)) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_frame();
        bin_result_t none;
        int n, kind, cnt;
        n = frame_words();
        kind = $urandom_range(0, 9);
        none = '{default: '0};
        cnt = (kind == 0) ? $urandom_range(1, n - 1) : n;
        repeat (cnt)
        begin
            send_word(ACT_LOAD, pick_sample(), pick_sample(), 0, none);
            sender_gap();
        end
        if (kind == 0)
        begin
            cnt = $urandom_range(0, 2);
        end
        else if (kind == 1)
        begin
            // Leaves bins behind so that the next load drops this frame.
            cnt = $urandom_range(0, n - 1);
        end
        else
        begin
            cnt = n + $urandom_range(0, 1);
        end
        repeat (cnt)
        begin
            send_word(ACT_READ, 16'($urandom), 16'($urandom), 0, none);
            sender_gap();
        end
    endtask

    // Results side: checking, pop bursts and the watchdog.
    always @(posedge clk)
    begin
        bin_result_t e;
        if (rst_n && pop && !empty)
        begin
            if (pending_bins.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected word: bin %0d re %0d im %0d last %0b",
                             bin_index, out_re, out_im, last_bin);
                end
            end
            else
            begin
                e = pending_bins.pop_front();
                if (bin_index !== e.bin || out_re !== e.re || out_im !== e.im ||
                    last_bin !== e.last)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch: expected bin %0d re %0d im %0d last %0b, got bin %0d re %0d im %0d last %0b",
                                 e.bin, $signed(e.re), $signed(e.im), e.last,
                                 bin_index, out_re, out_im, last_bin);
                    end
                end
            end
        end
        if (pop_hold > 0)
        begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            pop_hold <= $urandom_range(0, 18);
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
        if ((push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("radix2_fft_complex_and_real_top_tb NOT OK");
            $finish;
        end
    end

    dir_row_t dir_rows [24];
    logic [1:0] phase_mode [12];
    logic [3:0] phase_log [12];

    initial
    begin
        bin_result_t tv;
        int ph;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        push = 0; action = 0; in_re = '0; in_im = '0; pop = 0;
        rst_n = 0;
        errors = 0; items_sent = 0; calm = 0; last_was_load = 0;
        idle_cycles = 0; pop_hold = 0;
        for (int i = 0; i < 1024; i++)
        begin
            fr_re[i] = 0; fr_im[i] = 0;
        end
        cur_mode = r2fft_pkg::MODE_FWD; cur_log = 4'd10;
        loaded = 0; bins_read = 0; have_frame = 0;
        build_twiddles();
        dir_rows = '{
            '{1, 0, 0, 0, 0, 0, 0, 0},
            '{0, 32767, -32768, 0, 0, 0, 0, 0},
            '{0, 32767, -32768, 0, 0, 0, 0, 0},
            '{0, 32767, -32768, 0, 0, 0, 0, 0},
            '{0, 32767, -32768, 0, 0, 0, 0, 0},
            '{1, 0, 0, 1, 0, 131068, -131072, 0},
            '{1, 0, 0, 1, 1, 0, 0, 0},
            '{1, 0, 0, 1, 2, 0, 0, 0},
            '{1, 0, 0, 1, 3, 0, 0, 1},
            '{1, -1, -1, 0, 0, 0, 0, 0},
            '{0, -32768, 32767, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0, 0, 0, 0, 0},
            '{0, 1, -1, 0, 0, 0, 0, 0},
            '{0, 32767, 32767, 0, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 0, 0, 0},
            '{0, -32768, -32768, 0, 0, 0, 0, 0},
            '{0, 32767, 0, 0, 0, 0, 0, 0},
            '{0, -1, -1, 0, 0, 0, 0, 0},
            '{0, -32768, 32767, 0, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 0, 0, 0}
        };
        phase_mode = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd0, 2'd1, 2'd2};
        phase_log  = '{4'd2, 4'd3, 4'd0, 4'd4, 4'd5, 4'd2, 4'd1, 4'd15, 4'd8, 4'd3, 4'd4, 4'd5};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        reg_write(ADDR_MODE, 32'(r2fft_pkg::MODE_FWD));
        reg_write(ADDR_LOG, 32'd2);
        foreach (dir_rows[i])
        begin
            tv.bin = dir_rows[i].ebin[9:0];
            tv.re = dir_rows[i].ere;
            tv.im = dir_rows[i].eim;
            tv.last = dir_rows[i].elast;
            send_word(dir_rows[i].act, 16'(dir_rows[i].re), 16'(dir_rows[i].im),
                      dir_rows[i].typed, tv);
        end

        ph = 0;
        while (items_sent < ITEM_GOAL)
        begin
            drain();
            if (ph < 12)
            begin
                reg_write(ADDR_MODE, 32'(phase_mode[ph]));
                reg_write(ADDR_LOG, 32'(phase_log[ph]));
            end
            else
            begin
                reg_write(ADDR_MODE, 32'($urandom_range(0, 3)));
                reg_write(ADDR_LOG, 32'($urandom_range(2, 5)));
            end
            if (frame_words() >= 256)
            begin
                run_frame();
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    run_frame();
                    // Hold the sender back until the block has caught up.
                    if (ph == 0)
                    begin
                        drain();
                    end
                end
            end
            ph++;
        end

        push <= 1'b0;
        @(posedge clk);
        while (pending_bins.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (errors == 0)
        begin
            $display("radix2_fft_complex_and_real_top_tb OK");
        end
        else
        begin
            $display("radix2_fft_complex_and_real_top_tb NOT OK");
        end
        $finish;
    end

endmodule
